FILE: design/sttab_pkg.sv
// Package for the software timer slot table.
// Holds the slot entry type, action codes, scan state type and fixed limits.
// No dependencies.
`timescale 1ns / 1ps

package sttab_pkg;

    // Action codes carried in the action field of a command.
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_ADD      = 3'd1;
    localparam logic [2:0] ACT_KILL     = 3'd2;
    localparam logic [2:0] ACT_DISPATCH = 3'd3;
    localparam logic [2:0] ACT_QUERY    = 3'd4;
    localparam logic [2:0] ACT_READ     = 3'd5;

    // Most expired ids a single dispatch reports.
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] count;
        logic [15:0] reload;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

FILE: design/sttab_if.sv
// Handshake interfaces for the software timer slot table.
// Command channel and response channel; no dependencies.
`timescale 1ns / 1ps

interface sttab_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  timer_id;
    logic [15:0] start_time;
    logic [1:0]  timer_type;
    logic [31:0] previous_tick;

    modport source (output valid, action, timer_id, start_time, timer_type, previous_tick,
                    input ready);
    modport sink   (input valid, action, timer_id, start_time, timer_type, previous_tick,
                    output ready);
endinterface

interface sttab_rsp_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic        is_running;
    logic        expired_valid;
    logic [7:0]  expired_id;
    logic [31:0] tick_count;
    logic [31:0] elapsed;
    logic        last;

    modport source (output valid, success, is_running, expired_valid, expired_id,
                    tick_count, elapsed, last, input ready);
    modport sink   (input valid, success, is_running, expired_valid, expired_id,
                    tick_count, elapsed, last, output ready);
endinterface

FILE: design/software_timer_slot_table.sv
// Tick, add, kill, query and dispatch walk the slot table before their final transfer;
// read and unknown actions do not scan. A new command is accepted only in the idle state,
// after the last one has loaded its final response. The scan reads one slot per cycle
// through the single memory read port when not stalled, and that sets the rate.
// Dispatch may stall its scan while an expired id waits on the response channel.
// Reset: asynchronous, active low; all slots read as free at once through valid bits,
// so there is no clearing pass, and the tick counter and pending flag clear to zero.
`timescale 1ns / 1ps

// Top level of the software timer slot table.
// Instantiates the slot memory and the scan sequencer; uses sttab_pkg and sttab_if.sv.
module software_timer_slot_table #(
    parameter int SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    sttab_cmd_if.sink     cmd,
    sttab_rsp_if.source   rsp
);
    import sttab_pkg::*;

    // Slot index width; a one-slot table still gets a one-bit index.
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Every slot holds an id, a running count and a reload value. Each scanning command walks
    // the table from slot 0 upward: the memory is read one slot ahead while the current slot
    // is evaluated and written back, so in the walk no read meets a write to the same entry.
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    slot_t            rd_data;
    slot_t            wr_data;

    // Add records the matching slot and the lowest free slot during the walk, then writes
    // the chosen one after the walk ends. Dispatch keeps one expired id in hand so that it
    // knows which result is the last one of the command.
    sttab_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Slot storage with a registered read port.
    sttab_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

FILE: design/sttab_mem.sv
// Slot memory: one write port, one registered read port.
// Per-entry valid bits make never-written entries read as a free slot. Uses sttab_pkg.
`timescale 1ns / 1ps

module sttab_mem #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  rd_addr,
    output sttab_pkg::slot_t  rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  sttab_pkg::slot_t  wr_data
);
    import sttab_pkg::*;

    slot_t             slot_mem [SLOTS];
    slot_t             rd_data_reg;
    logic              rd_vld_reg;
    logic [SLOTS-1:0]  vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

FILE: design/sttab_ctrl.sv
// Scan sequencer for the software timer slot table.
// Walks the slots one per cycle unless stalled, writes back, drives the response register.
// Uses sttab_pkg and the interfaces in sttab_if.sv.
`timescale 1ns / 1ps

module sttab_ctrl #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    sttab_cmd_if.sink         cmd,
    sttab_rsp_if.source       rsp,
    output logic [IDX_W-1:0]  rd_addr,
    input  sttab_pkg::slot_t  rd_data,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output sttab_pkg::slot_t  wr_data
);
    import sttab_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [2:0]         act_reg;
    logic [7:0]         id_reg;
    logic [15:0]        start_reg;
    logic [1:0]         type_reg;
    logic [31:0]        prev_reg;
    logic               en_reg;
    logic [31:0]        tick_reg;
    logic               pending_reg;
    logic               hit_reg, free_reg, found_reg, run_reg;
    logic [IDX_W-1:0]   hit_idx_reg, free_idx_reg;
    logic               held_vld_reg;
    logic [7:0]         held_id_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic               out_vld_reg;
    logic               out_success_reg, out_run_reg, out_ev_reg, out_last_reg;
    logic [7:0]         out_id_reg;
    logic [31:0]        out_tick_reg, out_elapsed_reg;

    logic               accept, out_free, in_scan;
    logic               ident_match, expired, live;
    logic               cap, stall, last_slot, scan_end, push, done_load;
    logic               add_ok, start_en;
    logic               fin_success, fin_run, fin_ev;
    logic [7:0]         fin_id;
    logic [31:0]        fin_elapsed;

    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_vld_reg || rsp.ready;
    assign in_scan   = (state_reg == ST_SCAN);

    // Per-slot conditions on the entry whose read data is present this cycle.
    assign ident_match = en_reg && (rd_data.ident == id_reg);
    assign expired     = en_reg && (rd_data.ident != 8'd0) && (rd_data.count == 16'd0);
    assign live        = (rd_data.ident != 8'd0) && (rd_data.count != 16'd0);
    assign last_slot   = (idx_reg == LAST_IDX);
    assign add_ok      = en_reg && (hit_reg || free_reg);

    // Dispatch stops at the result cap, and holds the scan while an older id waits for
    // the response register.
    assign cap   = in_scan && (act_reg == ACT_DISPATCH) && expired &&
                   (cnt_reg == CNT_W'(MAX_RESULTS));
    assign stall = in_scan && (act_reg == ACT_DISPATCH) && expired && !cap &&
                   held_vld_reg && !out_free;
    assign scan_end  = cap || (last_slot && !stall);
    assign push      = in_scan && (act_reg == ACT_DISPATCH) && expired && !cap && !stall &&
                       held_vld_reg;
    assign done_load = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        unique case (cmd.action)
            ACT_TICK:               start_en = 1'b1;
            ACT_ADD:                start_en = (cmd.timer_id != 8'd0) && !cmd.timer_type[1];
            ACT_KILL, ACT_QUERY:    start_en = (cmd.timer_id != 8'd0);
            ACT_DISPATCH:           start_en = pending_reg;
            default:                start_en = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = (cmd.action <= ACT_QUERY) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory access and write-back.
    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data;
        unique case (state_reg)
            ST_SCAN:
            begin
                if (stall)
                begin
                    rd_addr = idx_reg;
                end
                else if (!last_slot)
                begin
                    rd_addr = IDX_W'(idx_reg + 1'b1);
                end
                unique case (act_reg)
                    ACT_TICK:
                    begin
                        if (live)
                        begin
                            wr_en         = 1'b1;
                            wr_data.count = rd_data.count - 16'd1;
                        end
                    end
                    ACT_KILL:
                    begin
                        if (ident_match && !found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_data = '0;
                        end
                    end
                    ACT_DISPATCH:
                    begin
                        if (expired && !cap && !stall)
                        begin
                            wr_en = 1'b1;
                            if (rd_data.reload != 16'd0)
                            begin
                                wr_data.count = rd_data.reload;
                            end
                            else
                            begin
                                wr_data = '0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DONE:
            begin
                if ((act_reg == ACT_ADD) && add_ok)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = hit_reg ? hit_idx_reg : free_idx_reg;
                    wr_data.ident  = id_reg;
                    wr_data.count  = start_reg;
                    wr_data.reload = type_reg[0] ? start_reg : 16'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Final result of the item.
    always_comb
    begin
        fin_success = 1'b0;
        fin_run     = 1'b0;
        fin_ev      = 1'b0;
        fin_id      = 8'd0;
        fin_elapsed = 32'd0;
        unique case (act_reg)
            ACT_TICK:     fin_success = 1'b1;
            ACT_ADD:      fin_success = add_ok;
            ACT_KILL:     fin_success = found_reg;
            ACT_DISPATCH:
            begin
                fin_success = 1'b1;
                fin_ev      = held_vld_reg;
                fin_id      = held_vld_reg ? held_id_reg : 8'd0;
            end
            ACT_QUERY:
            begin
                fin_success = 1'b1;
                fin_run     = run_reg;
            end
            ACT_READ:
            begin
                fin_success = 1'b1;
                fin_elapsed = tick_reg - prev_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tick_reg     <= 32'd0;
            pending_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            idx_reg      <= '0;
            act_reg      <= ACT_TICK;
            en_reg       <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            found_reg    <= 1'b0;
            run_reg      <= 1'b0;
            held_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                idx_reg      <= '0;
                act_reg      <= cmd.action;
                en_reg       <= start_en;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
                found_reg    <= 1'b0;
                run_reg      <= 1'b0;
                held_vld_reg <= 1'b0;
                cnt_reg      <= '0;
                if (cmd.action == ACT_TICK)
                begin
                    tick_reg <= tick_reg + 32'd1;
                end
                if (cmd.action == ACT_DISPATCH)
                begin
                    pending_reg <= 1'b0;
                end
            end
            else if (in_scan)
            begin
                if (!stall && !cap)
                begin
                    idx_reg <= IDX_W'(idx_reg + 1'b1);
                end
                unique case (act_reg)
                    ACT_TICK:
                    begin
                        if (live && (rd_data.count == 16'd1))
                        begin
                            pending_reg <= 1'b1;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (ident_match && !hit_reg)
                        begin
                            hit_reg <= 1'b1;
                        end
                        if (rd_data.ident == 8'd0 && !free_reg)
                        begin
                            free_reg <= 1'b1;
                        end
                    end
                    ACT_KILL:
                    begin
                        if (ident_match)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (ident_match && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            run_reg   <= (rd_data.count != 16'd0);
                        end
                    end
                    ACT_DISPATCH:
                    begin
                        if (cap)
                        begin
                            pending_reg <= 1'b1;
                        end
                        else if (expired && !stall)
                        begin
                            held_vld_reg <= 1'b1;
                            cnt_reg      <= CNT_W'(cnt_reg + 1'b1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (push || done_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg    <= cmd.timer_id;
            start_reg <= cmd.start_time;
            type_reg  <= cmd.timer_type;
            prev_reg  <= cmd.previous_tick;
        end
        if (in_scan && (act_reg == ACT_ADD))
        begin
            if (ident_match && !hit_reg)
            begin
                hit_idx_reg <= idx_reg;
            end
            if (rd_data.ident == 8'd0 && !free_reg)
            begin
                free_idx_reg <= idx_reg;
            end
        end
        if (in_scan && (act_reg == ACT_DISPATCH) && expired && !cap && !stall)
        begin
            held_id_reg <= rd_data.ident;
        end

        if (push)
        begin
            out_success_reg <= 1'b1;
            out_run_reg     <= 1'b0;
            out_ev_reg      <= 1'b1;
            out_id_reg      <= held_id_reg;
            out_tick_reg    <= tick_reg;
            out_elapsed_reg <= 32'd0;
            out_last_reg    <= 1'b0;
        end
        else if (done_load)
        begin
            out_success_reg <= fin_success;
            out_run_reg     <= fin_run;
            out_ev_reg      <= fin_ev;
            out_id_reg      <= fin_id;
            out_tick_reg    <= tick_reg;
            out_elapsed_reg <= fin_elapsed;
            out_last_reg    <= 1'b1;
        end
    end

    assign cmd.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_vld_reg;
    assign rsp.success       = out_success_reg;
    assign rsp.is_running    = out_run_reg;
    assign rsp.expired_valid = out_ev_reg;
    assign rsp.expired_id    = out_id_reg;
    assign rsp.tick_count    = out_tick_reg;
    assign rsp.elapsed       = out_elapsed_reg;
    assign rsp.last          = out_last_reg;

endmodule
